// ===== rtl/ptvp_pkg.sv =====
package ptvp_pkg;

    localparam int CoordWidthDef = 32;
    localparam int CoefWidthDef  = 16;
    localparam int CfgIdxWidth   = 3;
    localparam int CfgDataWidth  = 64;

    localparam logic [CfgIdxWidth-1:0] RegRow0   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegRow1   = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegRow2   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegRow3   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegOrigin = 3'd4;
    localparam logic [CfgIdxWidth-1:0] RegSize   = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegDepth  = 3'd6;

    localparam logic [63:0] Row0Reset   = 64'h0000_0000_0000_1000;
    localparam logic [63:0] Row1Reset   = 64'h0000_0000_1000_0000;
    localparam logic [63:0] Row2Reset   = 64'h0000_1000_0000_0000;
    localparam logic [63:0] Row3Reset   = 64'h1000_0000_0000_0000;
    localparam logic [31:0] OriginReset = 32'h0000_0000;
    localparam logic [31:0] SizeReset   = 32'h01E0_0280;
    localparam logic [31:0] DepthReset  = 32'h4000_0000;

    // quotient stages: 80 quotient bits, QBits resolved per stage
    localparam int QTotal  = 80;
    localparam int QBits   = 4;
    localparam int QStages = QTotal / QBits;

    localparam logic signed [63:0] NdcLimit = 64'sh100_0000_0000;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic [15:0]        screen_depth;
        logic               w_zero;
        logic               saturated;
    } t_out_item;

endpackage

// ===== rtl/ptvp_divider.sv =====
module ptvp_divider
    import ptvp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_valid,
    output logic [63:0] o_quot,
    output logic        o_over
);
    // restoring divider, QBits quotient bits per stage, num * 2^16 / den
    logic [QStages:0]         r_vld;
    logic [QStages:0][63:0]   r_num;
    logic [QStages:0][63:0]   r_den;
    logic [QStages:0][64:0]   r_rem;
    logic [QStages:0][63:0]   r_q;
    logic [QStages:0]         r_ov;

    assign r_vld[0] = i_valid;
    assign r_num[0] = i_num;
    assign r_den[0] = i_den;
    assign r_rem[0] = '0;
    assign r_q[0]   = '0;
    assign r_ov[0]  = 1'b0;

    for (genvar s = 0; s < QStages; s++) begin : g_st
        logic [64:0] n_rem;
        logic [63:0] n_q;
        logic        n_ov;
        logic        r_v;
        logic [63:0] r_n, r_d, r_qq;
        logic [64:0] r_r;
        logic        r_o;
        always_comb begin
            int unsigned bi;
            n_rem = r_rem[s];
            n_q   = r_q[s];
            n_ov  = r_ov[s];
            for (int k = 0; k < QBits; k++) begin
                bi = QTotal - 1 - (s * QBits + k);
                n_rem = {n_rem[63:0], (bi >= 16) ? r_num[s][6'(bi - 16)] : 1'b0};
                n_q   = {n_q[62:0], 1'b0};
                if (n_rem >= {1'b0, r_den[s]}) begin
                    n_rem = n_rem - {1'b0, r_den[s]};
                    n_q[0] = 1'b1;
                end
                if (n_q > 64'h100_0000_0000) n_ov = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v <= 1'b0;
            else if (i_en) r_v <= r_vld[s];
            if (i_en) begin
                r_n <= r_num[s]; r_d <= r_den[s];
                r_r <= n_rem; r_qq <= n_q; r_o <= n_ov;
            end
        end
        assign r_vld[s+1] = r_v;
        assign r_num[s+1] = r_n;
        assign r_den[s+1] = r_d;
        assign r_rem[s+1] = r_r;
        assign r_q[s+1]   = r_qq;
        assign r_ov[s+1]  = r_o;
    end

    assign o_valid = r_vld[QStages];
    assign o_quot  = r_q[QStages];
    assign o_over  = r_ov[QStages];
endmodule

// ===== rtl/point_transform_viewport_project.sv =====
// Point transform, perspective divide and viewport mapping.
// Input channel: i_in_valid / o_in_ready carry one point (Q16.16 x, y, z).
// Output channel: o_out_valid / i_out_ready carry screen x, y (Q16.16),
// depth (Q2.14), a zero-w flag and a saturation flag.
// Configuration: write i_cfg_we with i_cfg_idx / i_cfg_data; write only while
// the pipeline is empty. Unknown indexes are ignored.
// Throughput: one point per cycle unless the output is held. A 20-stage restoring
// divider (4 bits per stage) sits between the matrix stages and the viewport
// stages.
// Back-pressure: when the output register is full and not taken, the whole
// pipeline holds in place; o_in_ready drops and nothing is lost or repeated.
// Reset: synchronous, active low; clears the pipeline valids and loads an
// identity matrix, a 640x480 viewport at origin 0 and depth range 0..1.0.
module point_transform_viewport_project
    import ptvp_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef,
    parameter int COEF_WIDTH  = CoefWidthDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_data
);
    localparam logic signed [63:0] AccMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] CoordHi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] CoordLo = -CoordHi - 64'sd1;

    logic [3:0][63:0] r_row;
    logic [31:0] r_origin, r_size, r_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= Row0Reset; r_row[1] <= Row1Reset;
            r_row[2] <= Row2Reset; r_row[3] <= Row3Reset;
            r_origin <= OriginReset; r_size <= SizeReset; r_depth <= DepthReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegRow0:   r_row[0] <= i_cfg_data;
                RegRow1:   r_row[1] <= i_cfg_data;
                RegRow2:   r_row[2] <= i_cfg_data;
                RegRow3:   r_row[3] <= i_cfg_data;
                RegOrigin: r_origin <= i_cfg_data[31:0];
                RegSize:   r_size   <= i_cfg_data[31:0];
                RegDepth:  r_depth  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [63:0] coef(input logic [63:0] row, input int col);
        logic [15:0] sl;
        sl = row[16*col +: 16];
        return 64'(signed'(sl[COEF_WIDTH-1:0]));
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
            input logic signed [63:0] b, inout logic sat);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(AccMax)) begin sat = 1'b1; return AccMax; end
        if (s < -65'(AccMax)) begin sat = 1'b1; return -AccMax; end
        return s[63:0];
    endfunction

    // whole pipeline advances together unless the output is held
    logic en;
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: sign-extend, multiply
    logic r1_v;
    logic signed [3:0][2:0][63:0] r1_p;
    logic signed [3:0][63:0] r1_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_in_valid;
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r1_p[c][0] <= 64'(signed'(i_in_data.in_x[COORD_WIDTH-1:0])) * coef(r_row[0], c);
                r1_p[c][1] <= 64'(signed'(i_in_data.in_y[COORD_WIDTH-1:0])) * coef(r_row[1], c);
                r1_p[c][2] <= 64'(signed'(i_in_data.in_z[COORD_WIDTH-1:0])) * coef(r_row[2], c);
                r1_t[c]    <= coef(r_row[3], c) <<< 16;
            end
        end
    end

    // stage 2: saturating accumulate
    logic r2_v;
    logic signed [3:0][63:0] r2_acc;
    logic r2_sat;
    always_ff @(posedge i_clk) begin
        logic signed [63:0] a;
        logic s;
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
        if (en) begin
            s = 1'b0;
            for (int c = 0; c < 4; c++) begin
                a = r1_p[c][0];
                a = sat_add(a, r1_p[c][1], s);
                a = sat_add(a, r1_p[c][2], s);
                a = sat_add(a, r1_t[c], s);
                r2_acc[c] <= a;
            end
            r2_sat <= s;
        end
    end

    // stage 3: magnitudes for the divider
    logic r3_v, r3_sat, r3_wz;
    logic [2:0] r3_neg, r3_nsgn;
    logic [2:0][63:0] r3_a;
    logic [63:0] r3_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
        if (en) begin
            r3_wz  <= (r2_acc[3] == 64'sd0);
            r3_sat <= r2_sat;
            r3_b   <= r2_acc[3][63] ? 64'd0 - r2_acc[3] : r2_acc[3];
            for (int k = 0; k < 3; k++) begin
                r3_a[k]    <= r2_acc[k][63] ? 64'd0 - r2_acc[k] : r2_acc[k];
                r3_neg[k]  <= r2_acc[k][63] ^ r2_acc[3][63];
                r3_nsgn[k] <= r2_acc[k][63];
            end
        end
    end

    logic [2:0] dv_v, dv_ov;
    logic [2:0][63:0] dv_q;
    for (genvar k = 0; k < 3; k++) begin : g_div
        ptvp_divider u_div (
            .i_clk, .i_rst_n, .i_en(en), .i_valid(r3_v),
            .i_num(r3_a[k]), .i_den(r3_wz ? 64'd1 : r3_b),
            .o_valid(dv_v[k]), .o_quot(dv_q[k]), .o_over(dv_ov[k])
        );
    end

    // side info delay line matching the divider
    logic [QStages-1:0] r_dl_sat, r_dl_wz;
    logic [QStages-1:0][2:0] r_dl_neg, r_dl_nsgn;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_sat  <= {r_dl_sat[QStages-2:0], r3_sat};
            r_dl_wz   <= {r_dl_wz[QStages-2:0], r3_wz};
            r_dl_neg  <= {r_dl_neg[QStages-2:0], r3_neg};
            r_dl_nsgn <= {r_dl_nsgn[QStages-2:0], r3_nsgn};
        end
    end

    // stage 4: signed ndc and viewport operands
    logic r4_v, r4_sat, r4_wz;
    logic signed [63:0] r4_tx, r4_ty, r4_nz;
    always_ff @(posedge i_clk) begin
        logic signed [63:0] n [3];
        logic s, wz;
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= &dv_v;
        if (en) begin
            wz = r_dl_wz[QStages-1];
            s = r_dl_sat[QStages-1] | wz;
            for (int k = 0; k < 3; k++) begin
                if (wz) begin
                    n[k] = r_dl_nsgn[QStages-1][k] ? -NdcLimit : NdcLimit;
                end else begin
                    n[k] = dv_ov[k] ? NdcLimit : signed'(dv_q[k]);
                    if (dv_ov[k]) s = 1'b1;
                    if (r_dl_neg[QStages-1][k]) n[k] = -n[k];
                end
            end
            r4_tx <= 64'sd65536 + n[0];
            r4_ty <= 64'sd65536 - n[1];
            r4_nz <= n[2];
            r4_sat <= s;
            r4_wz  <= wz;
        end
    end

    // stage 5: viewport products
    logic r5_v, r5_sat, r5_wz;
    logic signed [63:0] r5_px, r5_py, r5_pz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
        if (en) begin
            r5_px <= r4_tx * signed'({48'd0, r_size[15:0]});
            r5_py <= r4_ty * signed'({48'd0, r_size[31:16]});
            r5_pz <= r4_nz * (signed'({48'd0, r_depth[31:16]}) - signed'({48'd0, r_depth[15:0]}));
            r5_sat <= r4_sat; r5_wz <= r4_wz;
        end
    end

    // stage 6: offset, clamp, output register
    t_out_item r_out;
    logic r_out_v;
    always_ff @(posedge i_clk) begin
        logic signed [63:0] sx, sy, d;
        logic s;
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en) r_out_v <= r5_v;
        if (en) begin
            s = r5_sat;
            sx = (r5_px >>> 1) + signed'({32'd0, r_origin[15:0], 16'd0});
            sy = (r5_py >>> 1) + signed'({32'd0, r_origin[31:16], 16'd0});
            d  = (r5_pz >>> 16) + signed'({48'd0, r_depth[15:0]});
            if (sx > CoordHi) begin sx = CoordHi; s = 1'b1; end
            if (sx < CoordLo) begin sx = CoordLo; s = 1'b1; end
            if (sy > CoordHi) begin sy = CoordHi; s = 1'b1; end
            if (sy < CoordLo) begin sy = CoordLo; s = 1'b1; end
            if (d < 64'sd0) begin d = 64'sd0; s = 1'b1; end
            if (d > 64'sd65535) begin d = 64'sd65535; s = 1'b1; end
            r_out.screen_x     <= sx[31:0];
            r_out.screen_y     <= sy[31:0];
            r_out.screen_depth <= d[15:0];
            r_out.w_zero       <= r5_wz;
            r_out.saturated    <= s;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_wz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.w_zero |-> o_out_data.saturated)
        else $error("w_zero without saturated");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("ready mismatch");
`endif
endmodule
